### sv/cdq_pkg.sv
// Shared constants, codes and item types for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int CAP_W      = 9;
   localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int VAL_W      = 32;
   localparam int MODE_W     = 3;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;

   localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] front_value;
      logic signed [VAL_W-1:0] rear_value;
      logic [CAP_W-1:0]        count;
      logic                    is_empty;
      logic                    is_full;
      logic                    dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;
      logic load;
   } cmd_type;

endpackage

### sv/cdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // Read data is the old contents on a same-address write.
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### sv/cdq_ctrl.sv
// Controller: item acceptance, result loading and the result valid flag.
`timescale 1ns / 1ps

module cdq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd.step = 1'b0;
      cmd.load = 1'b0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Read data waits in the RAM until the output register frees up.
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_follows_step: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> state_ff == ST_LOAD)
      else $error("load state not entered after an item was taken");

   a_rise_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOAD)
      else $error("result valid rose without a load");

endmodule

### sv/cdq_datapath.sv
// Datapath: deque indices, slot store, bypass and result register.
`timescale 1ns / 1ps

module cdq_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  cdq_pkg::cmd_type           cmd,
   input  cdq_pkg::req_type           req_data,
   input  logic                       csr_we,
   input  logic [cdq_pkg::CAP_W-1:0]  csr_wdata,
   output cdq_pkg::rsp_type           rsp_data
);
   import cdq_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_eff;
   logic [CMP_W-1:0] cap_wide;

   logic is_push, is_pop, full, empty, do_push, do_pop, drop;
   logic [SUM_W-1:0] cap_s, front_s, front_dec, front_inc, rear_wr, rear_rd, sum_wr, sum_rd;
   logic [IDX_W-1:0] wr_addr, rear_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic [DATA_WIDTH-1:0] byp_data_ff;
   logic                  byp_front_ff, byp_rear_ff;
   logic [CNT_W-1:0]      res_count_ff;
   logic                  res_full_ff, res_drop_ff;
   logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
   rsp_type               rsp_ff;

   // Capacity of zero acts as one, anything above the depth as the depth.
   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_wide > CMP_W'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_wide);
      end
   end

   // Front stays below the capacity and count at most the capacity, since
   // a capacity write empties the deque.
   always_comb begin
      is_push = req_data.mode inside {MODE_PUSH_FRONT, MODE_PUSH_REAR};
      is_pop  = req_data.mode inside {MODE_POP_FRONT, MODE_POP_REAR};
      full    = (count_ff == cap_eff);
      empty   = (count_ff == '0);
      do_push = is_push && !full;
      do_pop  = is_pop && !empty;
      drop    = (is_push && full) || (is_pop && empty);

      cap_s     = SUM_W'(cap_eff);
      front_s   = SUM_W'(front_ff);
      front_dec = (front_s == '0) ? cap_s - SUM_W'(1) : front_s - SUM_W'(1);
      front_inc = (front_s + SUM_W'(1) == cap_s) ? '0 : front_s + SUM_W'(1);

      sum_wr  = front_s + SUM_W'(count_ff);
      rear_wr = (sum_wr >= cap_s) ? sum_wr - cap_s : sum_wr;

      front_in = front_ff;
      count_in = count_ff;
      case (req_data.mode)
         MODE_PUSH_FRONT: begin
            if (do_push) begin
               front_in = IDX_W'(front_dec);
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_PUSH_REAR: begin
            if (do_push) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (do_pop) begin
               front_in = IDX_W'(front_inc);
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_POP_REAR: begin
            if (do_pop) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase

      wr_addr = (req_data.mode == MODE_PUSH_FRONT) ? IDX_W'(front_dec) : IDX_W'(rear_wr);
      wr_data = DATA_WIDTH'(req_data.value);

      // Rear slot after the step; meaningless when the deque ends up empty.
      sum_rd    = SUM_W'(front_in) + SUM_W'(count_in) - SUM_W'(1);
      rear_rd   = (sum_rd >= cap_s) ? sum_rd - cap_s : sum_rd;
      rear_addr = IDX_W'(rear_rd);
   end

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .we      (cmd.step && do_push),
      .waddr   (wr_addr),
      .wdata   (wr_data),
      .re      (cmd.step),
      .raddr_a (front_in),
      .raddr_b (rear_addr),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(DEPTH > 256 ? 256 : DEPTH);
         front_ff <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         cap_ff   <= csr_wdata;
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.step) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // The RAM returns old data on a same-slot write, so the pushed item is
   // forwarded from here.
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         byp_data_ff  <= wr_data;
         byp_front_ff <= do_push && (wr_addr == front_in);
         byp_rear_ff  <= do_push && (wr_addr == rear_addr);
         res_count_ff <= count_in;
         res_full_ff  <= (count_in == cap_eff);
         res_drop_ff  <= drop;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (res_count_ff == '0) begin
            rsp_ff.front_value <= EMPTY_VALUE;
            rsp_ff.rear_value  <= EMPTY_VALUE;
         end else begin
            rsp_ff.front_value <= VAL_W'(signed'(byp_front_ff ? byp_data_ff : rdata_a));
            rsp_ff.rear_value  <= VAL_W'(signed'(byp_rear_ff ? byp_data_ff : rdata_b));
         end
         rsp_ff.count    <= CAP_W'(res_count_ff);
         rsp_ff.is_empty <= (res_count_ff == '0);
         rsp_ff.is_full  <= res_full_ff;
         rsp_ff.dropped  <= res_drop_ff;
      end
   end

   assign rsp_data = rsp_ff;

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("element count exceeds capacity");

   a_front_in_cap: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(front_ff) < cap_eff)
      else $error("front index outside capacity");

   a_push_moves_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && do_push && !csr_we) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push did not grow the deque");

endmodule

### sv/circular_deque.sv
// Circular deque top level: controller, datapath and slot store.
// Timing: an accepted item moves the controller to its load state, where the read of the new
// front and rear slots from the registered-read slot store waits until the output register is
// free; the result is then loaded into it and rsp_valid rises. No new item is taken while a
// load is pending, and a stalled result holds back the next load.
// Reset: synchronous, active high; the deque is emptied and the capacity set to the depth.
// The slot store is not cleared: only slots written by a push are ever reported.
`timescale 1ns / 1ps

module circular_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [cdq_pkg::CAP_W-1:0] csr_wdata
);
   import cdq_pkg::*;

   cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cdq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

### test/tb_top.sv
// Self-checking testbench for the circular deque: random and directed items against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import cdq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NONE = 3'd4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRINT_LIMIT    = 40;

   // Predicts the front, rear and flags after each item and checks the results in order.
   class deque_scoreboard;
      logic [DATA_WIDTH-1:0] ring [DEPTH];
      int unsigned head_slot;
      int unsigned fill;
      int unsigned cap_setting;
      rsp_type status_q[$];
      int errors;
      int items_seen;
      int results_checked;
      int drops_seen;
      int full_seen;

      function new();
         head_slot = 0;
         fill = 0;
         cap_setting = DEPTH;
         errors = 0;
         items_seen = 0;
         results_checked = 0;
         drops_seen = 0;
         full_seen = 0;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      // A capacity write empties the deque but keeps the stored data.
      function void write_capacity(logic [CAP_W-1:0] v);
         cap_setting = 32'(v);
         head_slot = 0;
         fill = 0;
      endfunction

      function int unsigned usable_slots();
         int unsigned c;
         c = cap_setting;
         if (c == 0) c = 1;
         if (c > DEPTH) c = DEPTH;
         return c;
      endfunction

      function void apply_item(req_type item);
         int unsigned cap;
         rsp_type e;
         bit drop;
         cap = usable_slots();
         drop = 0;
         items_seen++;
         if (head_slot >= cap) head_slot = head_slot % cap;
         if (fill > cap) fill = cap;
         case (item.mode)
            MODE_PUSH_FRONT: begin
               if (fill >= cap) drop = 1;
               else begin
                  head_slot = (head_slot + cap - 1) % cap;
                  ring[IDX_W'(head_slot)] = item.value;
                  fill++;
               end
            end
            MODE_PUSH_REAR: begin
               if (fill >= cap) drop = 1;
               else begin
                  ring[IDX_W'((head_slot + fill) % cap)] = item.value;
                  fill++;
               end
            end
            MODE_POP_FRONT: begin
               if (fill == 0) drop = 1;
               else begin
                  head_slot = (head_slot + 1) % cap;
                  fill--;
               end
            end
            MODE_POP_REAR: begin
               if (fill == 0) drop = 1;
               else fill--;
            end
            default: ;
         endcase
         if (fill == 0) begin
            e.front_value = EMPTY_VALUE;
            e.rear_value  = EMPTY_VALUE;
         end else begin
            e.front_value = ring[IDX_W'(head_slot)];
            e.rear_value  = ring[IDX_W'((head_slot + fill - 1) % cap)];
         end
         e.count    = fill[CAP_W-1:0];
         e.is_empty = (fill == 0);
         e.is_full  = (fill == cap);
         e.dropped  = drop;
         if (drop) drops_seen++;
         if (e.is_full) full_seen++;
         status_q.push_back(e);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("mismatch on result %0d: %s got %0h want %0h",
                     results_checked, what, got, want);
      endtask

      task check_status(rsp_type got);
         rsp_type want;
         results_checked++;
         if (status_q.size() == 0) begin
            report_mismatch("result with no item pending", 32'(got.count), 0);
         end else begin
            want = status_q.pop_front();
            if (got.front_value !== want.front_value)
               report_mismatch("front_value", got.front_value, want.front_value);
            if (got.rear_value !== want.rear_value)
               report_mismatch("rear_value", got.rear_value, want.rear_value);
            if (got.count !== want.count)
               report_mismatch("count", 32'(got.count), 32'(want.count));
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
            if (got.is_full !== want.is_full)
               report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
            if (got.dropped !== want.dropped)
               report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   deque_scoreboard sb = new();
   bit idle_off = 0;
   int quiet_cycles = 0;
   int cap_writes = 0;

   circular_deque dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_item(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value);
      req_type it;
      it.mode = mode;
      it.value = value;
      return it;
   endfunction

   function automatic req_type random_item(int push_pct);
      int r;
      logic [MODE_W-1:0] mode;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         mode = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      else if (r < push_pct + 6)
         mode = MODE_NONE + MODE_W'($urandom_range(0, 3));
      else
         mode = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
      return make_item(mode, random_value());
   endfunction

   // Called at a falling edge; returns at the falling edge after the item was taken.
   task automatic send_item(req_type it);
      int gap;
      gap = (idle_off || $urandom_range(0, 99) < 55) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_data = it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] v);
      wait_quiet();
      csr_we = 1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      cap_writes++;
   endtask

   task automatic run_phase(logic [CAP_W-1:0] cap, int n_items, int push_pct, bit do_write);
      if (do_write) write_capacity(cap);
      idle_off = ($urandom_range(0, 3) == 0);
      repeat (n_items) send_item(random_item(push_pct));
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (idle_off) stall_left = 0;
         if (stall_left > 0) begin
            rsp_stall = 1;
            stall_left--;
         end else begin
            rsp_stall = 0;
            if (!idle_off && $urandom_range(0, 99) < 30) stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_status(rsp_data);
         if (req_valid && !req_stall) sb.apply_item(req_data);
         if (csr_we) sb.write_capacity(csr_wdata);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed items at the reset capacity: pops on empty, unused modes, extreme values.
      send_item(make_item(MODE_POP_FRONT, 32'h1234_5678));
      send_item(make_item(MODE_POP_REAR, 32'h0));
      send_item(make_item(MODE_NONE, 32'hffff_ffff));
      send_item(make_item(MODE_NONE + 3'd1, 32'h5555_5555));
      send_item(make_item(MODE_NONE + 3'd2, 32'haaaa_aaaa));
      send_item(make_item(MODE_NONE + 3'd3, 32'h0));
      send_item(make_item(MODE_PUSH_FRONT, 32'h7fff_ffff));
      send_item(make_item(MODE_PUSH_REAR, 32'h8000_0000));
      send_item(make_item(MODE_PUSH_FRONT, 32'hffff_ffff));
      send_item(make_item(MODE_PUSH_REAR, 32'h0));
      send_item(make_item(MODE_NONE, 32'h1));
      send_item(make_item(MODE_POP_FRONT, 32'h0));
      send_item(make_item(MODE_POP_REAR, 32'h0));
      send_item(make_item(MODE_POP_FRONT, 32'h0));
      send_item(make_item(MODE_POP_REAR, 32'h0));
      send_item(make_item(MODE_POP_REAR, 32'h0));
      send_item(make_item(MODE_PUSH_REAR, 32'h0000_0001));
      send_item(make_item(MODE_POP_FRONT, 32'h0));
      send_item(make_item(MODE_PUSH_FRONT, 32'h5a5a_a5a5));
      send_item(make_item(MODE_PUSH_REAR, 32'ha5a5_5a5a));

      // The first write lands with two elements held, so it must empty the deque.
      run_phase(1, 100, 50, 1);
      run_phase(0, 80, 45, 1);
      run_phase(2, 100, 50, 1);
      run_phase(3, 100, 55, 1);
      run_phase(511, 280, 96, 1);
      run_phase(511, 200, 10, 0);
      run_phase(257, 150, 55, 1);
      run_phase(5, 100, 50, 1);
      run_phase(CAP_W'($urandom_range(4, 40)), 150, 60, 1);
      run_phase(256, 170, 50, 1);

      req_valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d items over %0d capacity writes, %0d results compared",
               sb.items_seen, cap_writes, sb.results_checked);
      $display("%0d dropped operations, %0d results with the deque full, %0d mismatches",
               sb.drops_seen, sb.full_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### circular_deque.f
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
test/tb_top.sv
